/* sv/dpr_pkg.sv */
// Package for the disparity reprojection block: field widths, register
// indexes, saturation limits and the pixel and point transfer types.
// Depends on nothing; imported by every module of the block.
package dpr_pkg;

  // Fixed field widths
  localparam int COORD_BITS  = 13;
  localparam int DISP_W      = 16;
  localparam int CHAN_W      = 8;
  localparam int OUT_W       = 24;
  localparam int BASE_W      = 21;
  localparam int FOC_W       = 20;
  localparam int CTR_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = BASE_W;

  // Default number of fraction bits in the raw disparity
  localparam int DISP_FRAC_BITS_DEF = 8;

  // Quotient bits resolved by the divider, one per pipeline step
  localparam int QW = OUT_W;

  // Derived datapath widths
  localparam int BMAG_W    = BASE_W;
  localparam int SHIFTED_W = COORD_BITS + 4;
  localparam int DIFF_W    = (SHIFTED_W > CTR_W) ? SHIFTED_W : CTR_W;
  localparam int PF_W      = FOC_W + BMAG_W;
  localparam int PL_W      = BMAG_W + DIFF_W;
  localparam int PF_SPLIT  = PF_W / 2;
  localparam int PUHI_W    = PF_W - PF_SPLIT + DIFF_W;
  localparam int PULO_W    = PF_SPLIT + DIFF_W;
  localparam int PU_W      = PF_W + DIFF_W;
  localparam int MM_SCALE  = 16000;
  localparam int MM_SCALE_W = 14;
  localparam int DENF_W    = MM_SCALE_W + DISP_W;
  localparam int DENU_W    = FOC_W + DENF_W;

  // Saturation limits of a signed 24-bit coordinate
  localparam logic [OUT_W-1:0] SAT_POS     = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISP   = 3'd5;

  // Register reset values
  localparam logic signed [BASE_W-1:0] BASELINE_RESET = -21'sd232289;
  localparam logic [FOC_W-1:0]  FOCAL_X_RESET  = 20'd66945;
  localparam logic [FOC_W-1:0]  FOCAL_Y_RESET  = 20'd66945;
  localparam logic [CTR_W-1:0]  CENTER_X_RESET = 17'd15134;
  localparam logic [CTR_W-1:0]  CENTER_Y_RESET = 17'd8730;
  localparam logic [DISP_W-1:0] MIN_DISP_RESET = 16'd2560;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [DISP_W-1:0]     disparity_raw;
    logic [CHAN_W-1:0]     chan_first;
    logic [CHAN_W-1:0]     chan_second;
    logic [CHAN_W-1:0]     chan_third;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] forward_mm;
    logic signed [OUT_W-1:0] left_mm;
    logic signed [OUT_W-1:0] up_mm;
    logic [CHAN_W-1:0]       red_out;
    logic [CHAN_W-1:0]       green_out;
    logic [CHAN_W-1:0]       blue_out;
  } point_t;

endpackage

/* sv/disparity_to_point_reprojection.sv */
// Disparity pixel to 3D point reprojection, top level. Depends on dpr_pkg, dpr_div.
// Throughput: one pixel transfer per cycle while the skid is empty; every quotient
// step of the dividers is a stage. A point passes four arithmetic stages, one range
// check and 24 quotient steps before the output register. A skid register holds
// one finished point under output stall; pixels stall only while the skid is full.
// Reset (synchronous, rst high) empties the pipeline and loads register defaults.
module disparity_to_point_reprojection #(
  parameter int DISP_FRAC_BITS = dpr_pkg::DISP_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  dpr_pkg::pixel_t                pixel,
  output logic                           point_valid,
  input  logic                           point_stall,
  output dpr_pkg::point_t                point,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dpr_pkg::*;

  localparam int NUMF_W = PF_W + DISP_FRAC_BITS;
  localparam int NUML_W = PL_W + DISP_FRAC_BITS;
  localparam int NUMU_W = PU_W + DISP_FRAC_BITS;
  localparam int COL3_W = 3 * CHAN_W;

  // Configuration registers
  logic [BASE_W-1:0] baseline_um;
  logic [FOC_W-1:0]  focal_x_q4;
  logic [FOC_W-1:0]  focal_y_q4;
  logic [CTR_W-1:0]  center_x_q4;
  logic [CTR_W-1:0]  center_y_q4;
  logic [DISP_W-1:0] min_disparity_raw;

  logic              bneg;
  logic [BMAG_W-1:0] bmag;

  // Pipeline control
  logic en;
  logic skid_valid;

  // Stage one: offsets from the principal point
  logic [SHIFTED_W-1:0] u16, v16;
  logic [DIFF_W-1:0]    du_next, dv_next;
  logic                 uneg_next, vneg_next;
  logic                 s1_valid;
  logic [DISP_W-1:0]    s1_raw;
  logic [DIFF_W-1:0]    s1_du, s1_dv;
  logic                 s1_uneg, s1_vneg;
  logic [COL3_W-1:0]    s1_col;

  // Stage two: first products
  logic              s2_valid;
  logic [PF_W-1:0]   s2_pf;
  logic [PL_W-1:0]   s2_pl;
  logic [DENF_W-1:0] s2_den;
  logic [DIFF_W-1:0] s2_dv;
  logic              s2_uneg, s2_vneg;
  logic [COL3_W-1:0] s2_col;

  // Stage three: split product for the vertical axis, vertical divisor
  logic              s3_valid;
  logic [PUHI_W-1:0] s3_pu_hi;
  logic [PULO_W-1:0] s3_pu_lo;
  logic [DENU_W-1:0] s3_denu;
  logic [PF_W-1:0]   s3_pf;
  logic [PL_W-1:0]   s3_pl;
  logic [DENF_W-1:0] s3_den;
  logic              s3_uneg, s3_vneg;
  logic [COL3_W-1:0] s3_col;

  // Stage four: sum of partial products
  logic              s4_valid;
  logic [PU_W-1:0]   s4_pu;
  logic [DENU_W-1:0] s4_denu;
  logic [PF_W-1:0]   s4_pf;
  logic [PL_W-1:0]   s4_pl;
  logic [DENF_W-1:0] s4_den;
  logic              s4_uneg, s4_vneg;
  logic [COL3_W-1:0] s4_col;

  // Divider inputs and outputs
  logic [NUMF_W-1:0]       num_f;
  logic [NUML_W-1:0]       num_l;
  logic [NUMU_W-1:0]       num_u;
  logic signed [OUT_W-1:0] res_f, res_l, res_u;

  // Valid and colour alongside the divider stages
  logic              vpipe [0:QW];
  logic [COL3_W-1:0] cpipe [0:QW];

  // Output register and skid
  point_t res;
  point_t skid;
  logic   load_out_pipe, load_out_skid, load_skid;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_um       <= BASELINE_RESET;
      focal_x_q4        <= FOCAL_X_RESET;
      focal_y_q4        <= FOCAL_Y_RESET;
      center_x_q4       <= CENTER_X_RESET;
      center_y_q4       <= CENTER_Y_RESET;
      min_disparity_raw <= MIN_DISP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASELINE: baseline_um       <= cfg_data;
        REG_FOCAL_X:  focal_x_q4        <= cfg_data[FOC_W-1:0];
        REG_FOCAL_Y:  focal_y_q4        <= cfg_data[FOC_W-1:0];
        REG_CENTER_X: center_x_q4       <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y: center_y_q4       <= cfg_data[CTR_W-1:0];
        REG_MIN_DISP: min_disparity_raw <= cfg_data[DISP_W-1:0];
        default: ;
      endcase
    end
  end

  // Baseline sign and magnitude
  assign bneg = baseline_um[BASE_W-1];
  assign bmag = bneg ? BMAG_W'(~baseline_um + BASE_W'(1)) : baseline_um;

  // Advance the whole pipeline unless the skid holds a point
  assign en          = !skid_valid;
  assign pixel_stall = skid_valid;

  // Offsets of the pixel from the principal point, as sign and magnitude
  always_comb begin
    u16       = {pixel.column, 4'b0000};
    v16       = {pixel.row, 4'b0000};
    uneg_next = DIFF_W'(u16) < DIFF_W'(center_x_q4);
    vneg_next = DIFF_W'(v16) < DIFF_W'(center_y_q4);
    du_next   = uneg_next ? DIFF_W'(DIFF_W'(center_x_q4) - DIFF_W'(u16))
                          : DIFF_W'(DIFF_W'(u16) - DIFF_W'(center_x_q4));
    dv_next   = vneg_next ? DIFF_W'(DIFF_W'(center_y_q4) - DIFF_W'(v16))
                          : DIFF_W'(DIFF_W'(v16) - DIFF_W'(center_y_q4));
  end

  // Valid bits; drop pixels below the disparity threshold at entry
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel_valid && (pixel.disparity_raw >= min_disparity_raw);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_raw  <= pixel.disparity_raw;
      s1_du   <= du_next;
      s1_dv   <= dv_next;
      s1_uneg <= uneg_next;
      s1_vneg <= vneg_next;
      s1_col  <= {pixel.chan_first, pixel.chan_second, pixel.chan_third};

      s2_pf   <= PF_W'(focal_x_q4) * PF_W'(bmag);
      s2_pl   <= PL_W'(bmag) * PL_W'(s1_du);
      s2_den  <= DENF_W'(s1_raw) * DENF_W'(MM_SCALE);
      s2_dv   <= s1_dv;
      s2_uneg <= s1_uneg;
      s2_vneg <= s1_vneg;
      s2_col  <= s1_col;

      s3_pu_hi <= PUHI_W'(s2_pf[PF_W-1:PF_SPLIT]) * PUHI_W'(s2_dv);
      s3_pu_lo <= PULO_W'(s2_pf[PF_SPLIT-1:0]) * PULO_W'(s2_dv);
      s3_denu  <= DENU_W'(focal_y_q4) * DENU_W'(s2_den);
      s3_pf    <= s2_pf;
      s3_pl    <= s2_pl;
      s3_den   <= s2_den;
      s3_uneg  <= s2_uneg;
      s3_vneg  <= s2_vneg;
      s3_col   <= s2_col;

      s4_pu   <= (PU_W'(s3_pu_hi) << PF_SPLIT) + PU_W'(s3_pu_lo);
      s4_denu <= s3_denu;
      s4_pf   <= s3_pf;
      s4_pl   <= s3_pl;
      s4_den  <= s3_den;
      s4_uneg <= s3_uneg;
      s4_vneg <= s3_vneg;
      s4_col  <= s3_col;
    end
  end

  // Scale numerators by the disparity fraction
  assign num_f = NUMF_W'(s4_pf) << DISP_FRAC_BITS;
  assign num_l = NUML_W'(s4_pl) << DISP_FRAC_BITS;
  assign num_u = NUMU_W'(s4_pu) << DISP_FRAC_BITS;

  dpr_div #(.NUM_W(NUMF_W), .DEN_W(DENF_W)) u_div_forward (
    .clk    (clk),
    .en     (en),
    .num    (num_f),
    .den    (s4_den),
    .neg    (!bneg),
    .result (res_f)
  );

  dpr_div #(.NUM_W(NUML_W), .DEN_W(DENF_W)) u_div_left (
    .clk    (clk),
    .en     (en),
    .num    (num_l),
    .den    (s4_den),
    .neg    (bneg ^ s4_uneg),
    .result (res_l)
  );

  dpr_div #(.NUM_W(NUMU_W), .DEN_W(DENU_W)) u_div_up (
    .clk    (clk),
    .en     (en),
    .num    (num_u),
    .den    (s4_denu),
    .neg    (bneg ^ s4_vneg),
    .result (res_u)
  );

  // Carry valid and colour through the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) begin
        vpipe[k] <= 1'b0;
      end
    end else if (en) begin
      vpipe[0] <= s4_valid;
      for (int k = 1; k <= QW; k++) begin
        vpipe[k] <= vpipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cpipe[0] <= s4_col;
      for (int k = 1; k <= QW; k++) begin
        cpipe[k] <= cpipe[k-1];
      end
    end
  end

  // Assemble the finished point
  always_comb begin
    res.forward_mm = res_f;
    res.left_mm    = res_l;
    res.up_mm      = res_u;
    res.red_out    = cpipe[QW][COL3_W-1:2*CHAN_W];
    res.green_out  = cpipe[QW][2*CHAN_W-1:CHAN_W];
    res.blue_out   = cpipe[QW][CHAN_W-1:0];
  end

  // Output register takes the pipeline when free, else park the point in the skid
  assign load_out_pipe = en && (!point_valid || !point_stall);
  assign load_skid     = en && point_valid && point_stall && vpipe[QW];
  assign load_out_skid = skid_valid && !point_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      if (load_out_pipe) begin
        point_valid <= vpipe[QW];
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (load_out_skid) begin
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_pipe) begin
      point <= res;
    end else if (load_out_skid) begin
      point <= skid;
    end
    if (load_skid) begin
      skid <= res;
    end
  end

endmodule

/* sv/dpr_div.sv */
// Pipelined restoring divider: range check, one quotient bit per stage,
// signed saturation of the quotient to a 24-bit coordinate.
// Depends on dpr_pkg.
module dpr_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 30
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [NUM_W-1:0]                 num,
  input  logic [DEN_W-1:0]                 den,
  input  logic                             neg,
  output logic signed [dpr_pkg::OUT_W-1:0] result
);
  import dpr_pkg::*;

  localparam int T_W   = DEN_W + 1;
  localparam int CMP_W = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

  logic [DEN_W-1:0] rem   [0:QW-1];
  logic [QW-1:0]    low   [0:QW-1];
  logic [DEN_W-1:0] den_p [0:QW-1];
  logic [QW-1:0]    quo   [0:QW];
  logic             big   [0:QW];
  logic             zero  [0:QW];
  logic             sign  [0:QW];
  logic [OUT_W-1:0] mag;

  // Range check: a quotient of 2^24 or more, or a zero divisor with a nonzero numerator, saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= DEN_W'(num[NUM_W-1:QW]);
      low[0]   <= num[QW-1:0];
      den_p[0] <= den;
      quo[0]   <= '0;
      big[0]   <= CMP_W'(num) >= (CMP_W'(den) << QW);
      zero[0]  <= (num == '0);
      sign[0]  <= neg;
    end
  end

  // Quotient steps, most significant bit first
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [T_W-1:0] trial;
    logic           ge;

    assign trial = {rem[k-1], low[k-1][QW-1]};
    assign ge    = trial >= T_W'(den_p[k-1]);

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k]  <= {quo[k-1][QW-2:0], ge};
        big[k]  <= big[k-1];
        zero[k] <= zero[k-1];
        sign[k] <= sign[k-1];
      end
    end

    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k]   <= ge ? DEN_W'(trial - T_W'(den_p[k-1])) : DEN_W'(trial);
          low[k]   <= {low[k-1][QW-2:0], 1'b0};
          den_p[k] <= den_p[k-1];
        end
      end
    end
  end

  // Clamp the magnitude and apply the sign
  always_comb begin
    if (sign[QW]) begin
      mag = (big[QW] || quo[QW] > SAT_NEG_MAG) ? SAT_NEG_MAG : quo[QW];
    end else begin
      mag = (big[QW] || quo[QW] > SAT_POS) ? SAT_POS : quo[QW];
    end
    if (zero[QW]) begin
      result = '0;
    end else if (sign[QW]) begin
      result = $signed(OUT_W'(~mag + OUT_W'(1)));
    end else begin
      result = $signed(mag);
    end
  end

endmodule

/* sv/dpr_checker.sv */
// Port-level checks for the disparity reprojection block, with the bind
// that attaches them to the top level. Depends on dpr_pkg.
module dpr_checker (
  input logic            clk,
  input logic            rst,
  input logic            pixel_stall,
  input logic            point_valid,
  input logic            point_stall,
  input dpr_pkg::point_t point
);
  import dpr_pkg::*;

  // Hold a stalled point until its transfer
  assert property (@(posedge clk) disable iff (rst)
    point_valid && point_stall |=> point_valid && $stable(point))
    else $error("stalled point changed or vanished");

  // Back-pressure on pixels only while a point waits at the output
  assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> point_valid && $past(point_stall))
    else $error("pixel stall without a waiting point");

  // Release pixel back-pressure once the waiting point transfers
  assert property (@(posedge clk) disable iff (rst)
    pixel_stall && !point_stall |=> !pixel_stall)
    else $error("pixel stall held after output transfer");

  // Empty after reset
  assert property (@(posedge clk)
    rst |=> !point_valid && !pixel_stall)
    else $error("block not empty after reset");

endmodule

bind disparity_to_point_reprojection dpr_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_stall (pixel_stall),
  .point_valid (point_valid),
  .point_stall (point_stall),
  .point       (point)
);
